FILE: rtl/core/mrlc_pkg.sv
// ----------------------------------------------------------------------------
// mrlc_pkg
// Shared types, codes and keyword helpers for the modem response line
// classifier.
// ----------------------------------------------------------------------------
package mrlc_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);

    localparam int TIMEOUT_W = 16;
    localparam int LFWAIT_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd6000;
    localparam logic [LFWAIT_W-1:0]  LFWAIT_RST  = 8'd50;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_START = 2'd2,
        CMD_NOP   = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        OUT_OK      = 2'd0,
        OUT_ERROR   = 2'd1,
        OUT_TIMEOUT = 2'd2,
        OUT_NONE    = 2'd3
    } t_outcome;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESPONSE_TIMEOUT = 2'd0,
        REG_LF_WAIT          = 2'd1,
        REG_UNUSED2          = 2'd2,
        REG_UNUSED3          = 2'd3
    } t_cfg_reg;

    // Character at position p of "OK" matches c
    function automatic logic ok_char_hit(input logic [LEN_W-1:0] p, input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        if (p == LEN_W'(0)) begin
            hit = (c == "O");
        end else if (p == LEN_W'(1)) begin
            hit = (c == "K");
        end
        return hit;
    endfunction

    // Character at position p of "ERROR" matches c
    function automatic logic error_char_hit(input logic [LEN_W-1:0] p,
                                            input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        if (p == LEN_W'(0) || p == LEN_W'(3)) begin
            hit = (p == LEN_W'(0)) ? (c == "E") : (c == "O");
        end else if (p == LEN_W'(1) || p == LEN_W'(2) || p == LEN_W'(4)) begin
            hit = (c == "R");
        end
        return hit;
    endfunction

endpackage

FILE: rtl/core/modem_response_line_classifier_top.sv
// ----------------------------------------------------------------------------
// modem_response_line_classifier_top
// Watches received modem bytes for an OK or ERROR line under a tick deadline.
// ----------------------------------------------------------------------------
// Takes one item (tick, byte or start) per clock while not stalled. An accepted
// item lands in an input register and is processed from there by one level of
// line-state logic. A result, if any, is then loaded into the output register,
// so it passes through the input register and then the output register.
// The output register holds a stalled result while the input side keeps
// moving, so items that yield no result still flow.
// The input side stalls only when a result-producing item meets a stalled
// full output register. Configuration writes are always ready.
module modem_response_line_classifier_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_command,
    input  logic [7:0]                         i_rx_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [1:0]                         o_outcome,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mrlc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mrlc_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    localparam int LW = mrlc_pkg::LEN_W;

    // configuration
    logic [mrlc_pkg::TIMEOUT_W-1:0] r_timeout;
    logic [mrlc_pkg::LFWAIT_W-1:0]  r_lf_wait;

    // input register
    logic        r_in_valid;
    logic [1:0]  r_cmd;
    logic [7:0]  r_byte;

    // line state
    logic                           r_armed,     n_armed;
    logic [mrlc_pkg::TIMEOUT_W-1:0] r_time_left, n_time_left;
    logic                           r_seen_cr,   n_seen_cr;
    logic [mrlc_pkg::LFWAIT_W-1:0]  r_lf_left,   n_lf_left;
    logic [LW-1:0]                  r_len,       n_len;
    logic                           r_ok_p,      n_ok_p;
    logic                           r_err_p,     n_err_p;

    // output register
    logic        r_out_valid;
    logic [1:0]  r_outcome;

    mrlc_pkg::t_outcome res;
    logic               res_valid;
    logic               move;

    always_comb begin
        logic [LW-1:0] v_len;
        logic          v_ok_p;
        logic          v_err_p;
        logic          v_line_end;

        n_armed     = r_armed;
        n_time_left = r_time_left;
        n_seen_cr   = r_seen_cr;
        n_lf_left   = r_lf_left;
        n_len       = r_len;
        n_ok_p      = r_ok_p;
        n_err_p     = r_err_p;
        res         = mrlc_pkg::OUT_NONE;
        v_line_end  = 1'b0;

        v_len   = r_len;
        v_ok_p  = r_ok_p;
        v_err_p = r_err_p;

        case (mrlc_pkg::t_command'(r_cmd))
            mrlc_pkg::CMD_START: begin
                n_armed     = 1'b1;
                n_time_left = r_timeout;
                n_seen_cr   = 1'b0;
                n_lf_left   = '0;
                n_len       = '0;
                n_ok_p      = 1'b1;
                n_err_p     = 1'b1;
            end
            mrlc_pkg::CMD_TICK: begin
                if (r_armed) begin
                    if (r_time_left <= mrlc_pkg::TIMEOUT_W'(1)) begin
                        n_time_left = '0;
                        res         = mrlc_pkg::OUT_TIMEOUT;
                    end else begin
                        n_time_left = r_time_left - mrlc_pkg::TIMEOUT_W'(1);
                        if (r_seen_cr) begin
                            if (r_lf_left <= mrlc_pkg::LFWAIT_W'(1)) begin
                                v_line_end = 1'b1;
                            end else begin
                                n_lf_left = r_lf_left - mrlc_pkg::LFWAIT_W'(1);
                            end
                        end
                    end
                end
            end
            mrlc_pkg::CMD_BYTE: begin
                if (r_armed) begin
                    // a pending CR closes the line first; a non-LF byte then
                    // starts the next line
                    if (r_seen_cr) begin
                        v_line_end = 1'b1;
                        v_len      = '0;
                        v_ok_p     = 1'b1;
                        v_err_p    = 1'b1;
                    end
                    if (r_seen_cr && r_byte == mrlc_pkg::CHAR_LF) begin
                        // LF consumed by the CR line end
                    end else if (r_byte == mrlc_pkg::CHAR_CR) begin
                        n_seen_cr = 1'b1;
                        n_lf_left = r_lf_wait;
                        n_len     = v_len;
                        n_ok_p    = v_ok_p;
                        n_err_p   = v_err_p;
                    end else if (r_byte == mrlc_pkg::CHAR_LF) begin
                        v_line_end = 1'b1;
                    end else begin
                        n_seen_cr = 1'b0;
                        n_lf_left = '0;
                        n_len     = v_len;
                        n_ok_p    = v_ok_p;
                        n_err_p   = v_err_p;
                        if (v_len < LW'(mrlc_pkg::LINE_CAPACITY - 1)) begin
                            n_ok_p  = v_ok_p && mrlc_pkg::ok_char_hit(v_len, r_byte);
                            n_err_p = v_err_p && mrlc_pkg::error_char_hit(v_len, r_byte);
                            n_len   = v_len + LW'(1);
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // classify the finished line (uses the line as it stood before this item)
        if (v_line_end) begin
            if (r_len == LW'(2) && r_ok_p) begin
                res = mrlc_pkg::OUT_OK;
            end else if (r_len == LW'(5) && r_err_p) begin
                res = mrlc_pkg::OUT_ERROR;
            end
            if (!(r_seen_cr && r_cmd == mrlc_pkg::CMD_BYTE &&
                  r_byte != mrlc_pkg::CHAR_LF)) begin
                n_seen_cr = 1'b0;
                n_lf_left = '0;
                n_len     = '0;
                n_ok_p    = 1'b1;
                n_err_p   = 1'b1;
            end
        end

        res_valid = (res != mrlc_pkg::OUT_NONE);
        if (res_valid) begin
            n_armed   = 1'b0;
            n_seen_cr = 1'b0;
            n_lf_left = '0;
            n_len     = '0;
            n_ok_p    = 1'b1;
            n_err_p   = 1'b1;
        end
    end

    assign move       = r_in_valid && (!res_valid || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= mrlc_pkg::TIMEOUT_RST;
            r_lf_wait <= mrlc_pkg::LFWAIT_RST;
        end else if (i_cfg_valid) begin
            case (mrlc_pkg::t_cfg_reg'(i_cfg_index))
                mrlc_pkg::REG_RESPONSE_TIMEOUT: r_timeout <= i_cfg_data;
                mrlc_pkg::REG_LF_WAIT:          r_lf_wait <= i_cfg_data[mrlc_pkg::LFWAIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_cmd  <= i_command;
            r_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_time_left <= '0;
            r_seen_cr   <= 1'b0;
            r_lf_left   <= '0;
            r_len       <= '0;
            r_ok_p      <= 1'b1;
            r_err_p     <= 1'b1;
        end else if (move) begin
            r_armed     <= n_armed;
            r_time_left <= n_time_left;
            r_seen_cr   <= n_seen_cr;
            r_lf_left   <= n_lf_left;
            r_len       <= n_len;
            r_ok_p      <= n_ok_p;
            r_err_p     <= n_err_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= move && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            r_outcome <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_outcome   = r_outcome;
    assign o_cfg_ready = 1'b1;

endmodule

FILE: rtl/core/mrlc_checker.sv
// ----------------------------------------------------------------------------
// mrlc_checker
// Port-level checks for the modem response line classifier.
// ----------------------------------------------------------------------------
module mrlc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [1:0]                         o_outcome
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_outcome))
        else $error("stalled result changed");

    // only OK, ERROR or timeout codes are ever delivered
    a_out_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_outcome != mrlc_pkg::OUT_NONE)
        else $error("result carries no-result code");

    // a fresh result follows an accepted input transaction
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result without a causing input");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind modem_response_line_classifier_top mrlc_checker u_mrlc_checker (.*);
